// File: hdl/wsp_pkg.sv
package wsp_pkg;

  localparam int CLIP_W     = 51;  // exact clip coordinate, Q.26
  localparam int DIV_W      = 52;  // divider numerator, denominator and remainder
  localparam int FRAC_BITS  = 32;  // fraction bits of the Q1.32 ratio
  localparam int QUOT_W     = FRAC_BITS + 1;
  localparam int PROD_W     = QUOT_W + 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_VP_EMPTY = 3'd1;
  localparam logic [2:0] ST_FB_EMPTY = 3'd2;
  localparam logic [2:0] ST_BEHIND   = 3'd3;
  localparam logic [2:0] ST_W_ZERO   = 3'd4;
  localparam logic [2:0] ST_X_OUT    = 3'd5;
  localparam logic [2:0] ST_Y_OUT    = 3'd6;

  localparam logic [2:0] REG_ROW0    = 3'd0;
  localparam logic [2:0] REG_ROW1    = 3'd1;
  localparam logic [2:0] REG_ROW2    = 3'd2;
  localparam logic [2:0] REG_ROW3    = 3'd3;
  localparam logic [2:0] REG_NEAR    = 3'd4;
  localparam logic [2:0] REG_FB_SIZE = 3'd5;
  localparam logic [2:0] REG_VP_SIZE = 3'd6;
  localparam logic [2:0] REG_VP_POS  = 3'd7;

  typedef struct packed {
    logic [2:0]       status;
    logic             absolute;
    logic [DIV_W-1:0] num_x;
    logic [DIV_W-1:0] num_y;
    logic [DIV_W-1:0] den;
  } wsp_item_t;

endpackage

// File: hdl/wsp_front.sv
module wsp_front import wsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  world_x,
  input  logic signed [31:0]  world_y,
  input  logic signed [31:0]  world_z,
  input  logic                absolute,
  input  logic [3:0][63:0]    matrix,
  input  logic [30:0]         near_clip,
  input  logic [31:0]         framebuffer_size,
  input  logic [31:0]         viewport_size,
  output logic                item_valid,
  input  logic                item_ready,
  output wsp_item_t           item
);

  logic en;

  // stage 1: products
  logic                      v1;
  logic [2:0]                st1;
  logic                      abs1;
  logic signed [47:0]        p1 [4][3];
  logic signed [15:0]        t1 [4];

  // stage 2: clip coordinates
  logic                      v2;
  logic [2:0]                st2;
  logic                      abs2;
  logic signed [CLIP_W-1:0]  c2 [4];

  // stage 3: classified item
  logic                      v3;

  logic [2:0]                st_in;
  logic [2:0]                st3_next;
  logic signed [CLIP_W-1:0]  near_neg;
  logic signed [DIV_W-1:0]   n_x, n_y;
  logic [CLIP_W-1:0]         mag_x, mag_y, mag_w;

  function automatic logic [CLIP_W-1:0] mag(input logic signed [CLIP_W-1:0] v);
    return v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
  endfunction

  assign en       = !v3 || item_ready;
  assign in_ready = en;

  always_comb begin
    if (viewport_size[15:0] == '0 || viewport_size[31:16] == '0) begin
      st_in = ST_VP_EMPTY;
    end else if (framebuffer_size[15:0] == '0 || framebuffer_size[31:16] == '0) begin
      st_in = ST_FB_EMPTY;
    end else begin
      st_in = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1  <= st_in;
      abs1 <= absolute;
      for (int r = 0; r < 4; r++) begin
        p1[r][0] <= $signed(matrix[r][15:0])  * world_x;
        p1[r][1] <= $signed(matrix[r][31:16]) * world_y;
        p1[r][2] <= $signed(matrix[r][47:32]) * world_z;
        t1[r]    <= $signed(matrix[r][63:48]);
      end
      st2  <= st1;
      abs2 <= abs1;
      for (int r = 0; r < 4; r++) begin
        c2[r] <= CLIP_W'(p1[r][0]) + CLIP_W'(p1[r][1]) + CLIP_W'(p1[r][2])
               + (CLIP_W'(t1[r]) <<< 26);
      end
    end
  end

  assign near_neg = -$signed({{(CLIP_W-41){1'b0}}, near_clip, 10'b0});
  assign mag_x    = mag(c2[0]);
  assign mag_y    = mag(c2[1]);
  assign mag_w    = mag(c2[3]);
  assign n_x      = DIV_W'(c2[0]) + DIV_W'(c2[3]);
  assign n_y      = DIV_W'(c2[1]) + DIV_W'(c2[3]);

  always_comb begin
    if (st2 != ST_OK) begin
      st3_next = st2;
    end else if (c2[2] > near_neg) begin
      st3_next = ST_BEHIND;
    end else if (c2[3] == '0) begin
      st3_next = ST_W_ZERO;
    end else if (mag_x > mag_w) begin
      st3_next = ST_X_OUT;
    end else if (mag_y > mag_w) begin
      st3_next = ST_Y_OUT;
    end else begin
      st3_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item.status   <= st3_next;
      item.absolute <= abs2;
      // flip the numerator sign with w so the ratio stays positive
      item.num_x    <= c2[3][CLIP_W-1] ? DIV_W'(-n_x) : DIV_W'(n_x);
      item.num_y    <= c2[3][CLIP_W-1] ? DIV_W'(-n_y) : DIV_W'(n_y);
      item.den      <= {1'b0, mag_w} << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign item_valid = v3;

endmodule

// File: hdl/wsp_queue.sv
module wsp_queue import wsp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  wsp_item_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output wsp_item_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsp_item_t        mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count lost a push");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    pop_valid == (count != '0)) else $error("queue empty flag wrong");
`endif

endmodule

// File: hdl/wsp_back.sv
module wsp_back import wsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  wsp_item_t          item,
  input  logic [31:0]        viewport_size,
  input  logic [31:0]        viewport_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               visible,
  output logic [2:0]         status,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y
);

  logic en;

  logic              vld   [FRAC_BITS+1];
  logic [2:0]        st    [FRAC_BITS+1];
  logic              absf  [FRAC_BITS+1];
  logic [DIV_W-1:0]  den   [FRAC_BITS+1];
  logic [DIV_W-1:0]  rem_x [FRAC_BITS+1];
  logic [DIV_W-1:0]  rem_y [FRAC_BITS+1];
  logic [QUOT_W-1:0] q_x   [FRAC_BITS+1];
  logic [QUOT_W-1:0] q_y   [FRAC_BITS+1];

  logic              mv;
  logic [2:0]        mst;
  logic              mabs;
  logic [PROD_W-1:0] prod_x, prod_y;

  logic              ge0_x, ge0_y;

  function automatic logic signed [31:0] place(input logic [PROD_W-1:0] p,
                                               input logic signed [15:0] off,
                                               input logic add);
    logic signed [34:0] v;
    v = $signed({2'b0, p[PROD_W-1:16]});
    if (add) begin
      v = v + $signed({{3{off[15]}}, off, 16'h0});
    end
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign en         = !out_valid || out_ready;
  assign item_ready = en;

  assign ge0_x = item.num_x >= item.den;
  assign ge0_y = item.num_y >= item.den;

  // integer bit of the ratio
  always_ff @(posedge clk) begin
    if (en) begin
      st[0]    <= item.status;
      absf[0]  <= item.absolute;
      den[0]   <= item.den;
      rem_x[0] <= ge0_x ? item.num_x - item.den : item.num_x;
      rem_y[0] <= ge0_y ? item.num_y - item.den : item.num_y;
      q_x[0]   <= QUOT_W'(ge0_x);
      q_y[0]   <= QUOT_W'(ge0_y);
    end
  end

  // one fraction bit per stage
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [DIV_W-1:0] sh_x, sh_y;
    logic             ge_x, ge_y;
    assign sh_x = {rem_x[k-1][DIV_W-2:0], 1'b0};
    assign sh_y = {rem_y[k-1][DIV_W-2:0], 1'b0};
    assign ge_x = sh_x >= den[k-1];
    assign ge_y = sh_y >= den[k-1];
    always_ff @(posedge clk) begin
      if (en) begin
        st[k]    <= st[k-1];
        absf[k]  <= absf[k-1];
        den[k]   <= den[k-1];
        rem_x[k] <= ge_x ? sh_x - den[k-1] : sh_x;
        rem_y[k] <= ge_y ? sh_y - den[k-1] : sh_y;
        q_x[k]   <= {q_x[k-1][QUOT_W-2:0], ge_x};
        q_y[k]   <= {q_y[k-1][QUOT_W-2:0], ge_y};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= FRAC_BITS; k++) begin
        vld[k] <= 1'b0;
      end
      mv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= item_valid;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        vld[k] <= vld[k-1];
      end
      mv        <= vld[FRAC_BITS];
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mst    <= st[FRAC_BITS];
      mabs   <= absf[FRAC_BITS];
      prod_x <= q_x[FRAC_BITS] * viewport_size[15:0];
      prod_y <= q_y[FRAC_BITS] * viewport_size[31:16];
      status <= mst;
      if (mst == ST_OK) begin
        visible  <= 1'b1;
        screen_x <= place(prod_x, $signed(viewport_position[15:0]), mabs);
        screen_y <= place(prod_y, $signed(viewport_position[31:16]), mabs);
      end else begin
        visible  <= 1'b0;
        screen_x <= '0;
        screen_y <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_visible_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> visible == (status == ST_OK)) else $error("visible disagrees with status");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> screen_x == '0 && screen_y == '0)
    else $error("rejected point carries a position");
  a_enter_pipe: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> vld[0]) else $error("transfer from queue lost");
`endif

endmodule

// File: hdl/world_to_screen_projection.sv
// Projects one Q16.16 world point per clock, while no back-pressure from the output
// stalls the pipeline, through a configured view-projection matrix and returns its
// Q16.16 screen position with a status code; every point gives exactly one result.
// A point passes the matrix product, clip sum and classification stages, the small
// queue, then the back end: the 33 one-bit stages of the x/y ratio divider plus the
// extent multiply and the offset/saturate stage. Write configuration only while no
// point is in flight.
module world_to_screen_projection import wsp_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic               absolute,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               visible,
  output logic [2:0]         status,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y
);

  logic [3:0][63:0] matrix;
  logic [30:0]      near_clip;
  logic [31:0]      framebuffer_size;
  logic [31:0]      viewport_size;
  logic [31:0]      viewport_position;

  logic      f_valid, f_ready, b_valid, b_ready;
  wsp_item_t f_item, b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix            <= '0;
      near_clip         <= '0;
      framebuffer_size  <= '0;
      viewport_size     <= '0;
      viewport_position <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0:    matrix[0]         <= cfg_data;
        REG_ROW1:    matrix[1]         <= cfg_data;
        REG_ROW2:    matrix[2]         <= cfg_data;
        REG_ROW3:    matrix[3]         <= cfg_data;
        REG_NEAR:    near_clip         <= cfg_data[30:0];
        REG_FB_SIZE: framebuffer_size  <= cfg_data[31:0];
        REG_VP_SIZE: viewport_size     <= cfg_data[31:0];
        REG_VP_POS:  viewport_position <= cfg_data[31:0];
        default:     ;
      endcase
    end
  end

  wsp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .world_x          (world_x),
    .world_y          (world_y),
    .world_z          (world_z),
    .absolute         (absolute),
    .matrix           (matrix),
    .near_clip        (near_clip),
    .framebuffer_size (framebuffer_size),
    .viewport_size    (viewport_size),
    .item_valid       (f_valid),
    .item_ready       (f_ready),
    .item             (f_item)
  );

  wsp_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_item)
  );

  wsp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (b_valid),
    .item_ready        (b_ready),
    .item              (b_item),
    .viewport_size     (viewport_size),
    .viewport_position (viewport_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .visible           (visible),
    .status            (status),
    .screen_x          (screen_x),
    .screen_y          (screen_y)
  );

endmodule

// File: dv/tb_world_to_screen_projection.sv
`timescale 1ns / 1ps

module tb_world_to_screen_projection;
  import wsp_pkg::*;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               abs_flag;
  } point_t;

  typedef struct {
    logic               vis;
    logic [2:0]         st;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } proj_t;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_ROW0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] world_x = '0;
  logic signed [31:0] world_y = '0;
  logic signed [31:0] world_z = '0;
  logic               absolute = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               visible;
  logic [2:0]         status;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;

  world_to_screen_projection DUT (.*);

  always #4 clk = ~clk;

  // shadow copy of the block's registers
  logic [63:0] mat_row [4];
  logic [30:0] near_dist;
  logic [31:0] fb_size, vp_size, vp_pos;

  point_t pending_points [$];
  proj_t  expected_proj [$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     in_gap = 0;
  int     out_gap = 0;
  bit     quiet_out = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint clip_coord(logic [63:0] row, point_t p);
    longint acc;
    acc = longint'($signed(row[15:0])) * longint'(p.wx)
        + longint'($signed(row[31:16])) * longint'(p.wy)
        + longint'($signed(row[47:32])) * longint'(p.wz)
        + longint'($signed(row[63:48])) * 64'sd67108864;
    return acc;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned ratio_q32(longint c, longint w);
    longint n;
    longint unsigned num, den, q, rem;
    n = c + w;
    num = w < 0 ? -n : n;
    den = mag(w) * 2;
    q = 0;
    rem = num;
    if (num >= den) begin
      q = 1;
      rem = num - den;
    end
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [31:0] pixel_pos(longint unsigned frac, logic [15:0] extent,
                                                   logic signed [15:0] origin, logic add);
    longint v;
    v = longint'((frac * extent) >> 16);
    if (add) v += longint'(origin) * 65536;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic proj_t project_point(point_t p);
    proj_t  r;
    longint cx, cy, cz, cw;
    r.st = ST_OK;
    cx = 0;
    cy = 0;
    cw = 0;
    if (vp_size[15:0] == 0 || vp_size[31:16] == 0) r.st = ST_VP_EMPTY;
    else if (fb_size[15:0] == 0 || fb_size[31:16] == 0) r.st = ST_FB_EMPTY;
    else begin
      cx = clip_coord(mat_row[0], p);
      cy = clip_coord(mat_row[1], p);
      cz = clip_coord(mat_row[2], p);
      cw = clip_coord(mat_row[3], p);
      if (cz > -(longint'(near_dist) * 1024)) r.st = ST_BEHIND;
      else if (cw == 0) r.st = ST_W_ZERO;
      else if (mag(cx) > mag(cw)) r.st = ST_X_OUT;
      else if (mag(cy) > mag(cw)) r.st = ST_Y_OUT;
    end
    r.vis = (r.st == ST_OK);
    r.sx = '0;
    r.sy = '0;
    if (r.vis) begin
      r.sx = pixel_pos(ratio_q32(cx, cw), vp_size[15:0], vp_pos[15:0], p.abs_flag);
      r.sy = pixel_pos(ratio_q32(cy, cw), vp_size[31:16], vp_pos[31:16], p.abs_flag);
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_proj.push_back(project_point('{world_x, world_y, world_z, absolute}));
        in_gap <= gap_len();
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0 && !(in_valid && in_ready)) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_points.size() > 0 && (in_gap == 0 || (in_valid && in_ready))
                     && !(in_valid && in_ready && gap_len() != 0)) begin
          in_valid <= 1'b1;
          world_x <= pending_points[0].wx;
          world_y <= pending_points[0].wy;
          world_z <= pending_points[0].wz;
          absolute <= pending_points[0].abs_flag;
          void'(pending_points.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_proj.size() == 0) begin
          $display("%0t: unexpected result status=%0d", $time, status);
          error_count++;
        end else begin
          proj_t e;
          e = expected_proj.pop_front();
          if (visible !== e.vis || status !== e.st || screen_x !== e.sx
              || screen_y !== e.sy) begin
            $display("%0t: mismatch exp vis=%0d st=%0d x=%h y=%h got vis=%0d st=%0d x=%h y=%h",
                     $time, e.vis, e.st, e.sx, e.sy, visible, status, screen_x, screen_y);
            error_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else if (quiet_out) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
        out_gap <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** world_to_screen_projection: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mat_row[idx] = val;
      REG_NEAR:    near_dist = val[30:0];
      REG_FB_SIZE: fb_size = val[31:0];
      REG_VP_SIZE: vp_size = val[31:0];
      default:     vp_pos = val[31:0];
    endcase
  endtask

  // sample on the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_proj.size() > 0) @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] q610(int milli);
    return 16'((milli * 1024) / 1000);
  endfunction

  // typical perspective-like matrix: cz = z, cw = -z + bias_w
  task automatic load_camera(int sx, int sy, int bias_w);
    write_reg(REG_ROW0, {16'h0, 16'h0, 16'h0, q610(sx)});
    write_reg(REG_ROW1, {16'h0, 16'h0, q610(sy), 16'h0});
    write_reg(REG_ROW2, {16'h0, q610(1000), 16'h0, 16'h0});
    write_reg(REG_ROW3, {q610(bias_w), q610(-1000), 16'h0, 16'h0});
  endtask

  function automatic point_t rand_point(bit wide);
    point_t p;
    if (wide) begin
      p.wx = $urandom;
      p.wy = $urandom;
      p.wz = $urandom;
    end else begin
      p.wx = $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
      p.wy = $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
      p.wz = -$signed($urandom_range(0, 32'h0010_0000));
    end
    p.abs_flag = $urandom_range(0, 1);
    return p;
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) pending_points.push_back(rand_point($urandom_range(0, 9) == 0));
  endtask

  initial begin
    for (int i = 0; i < 4; i++) mat_row[i] = '0;
    near_dist = '0;
    fb_size = '0;
    vp_size = '0;
    vp_pos = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: viewport empty
    pending_points.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 1'b1});
    drain();
    write_reg(REG_VP_SIZE, 64'h0000_0000_0438_0780);
    pending_points.push_back('{32'sh0, 32'sh0, 32'sh0, 1'b0});
    drain();
    write_reg(REG_FB_SIZE, 64'h0000_0000_0438_0780);
    write_reg(REG_NEAR, 64'h0000_0000_0000_1000);
    write_reg(REG_VP_POS, 64'h0000_0000_FF00_0040);
    load_camera(1000, 1000, 0);
    // directed: behind, x out, y out, edges, extremes
    pending_points.push_back('{32'sh0, 32'sh0, 32'sh0001_0000, 1'b0});
    pending_points.push_back('{32'sh0, 32'sh0, 32'sh0, 1'b0});
    pending_points.push_back('{32'sh0003_0000, 32'sh0, -32'sh0002_0000, 1'b1});
    pending_points.push_back('{32'sh0, -32'sh0003_0000, -32'sh0002_0000, 1'b1});
    pending_points.push_back('{32'sh0002_0000, 32'sh0002_0000, -32'sh0002_0000, 1'b1});
    pending_points.push_back('{-32'sh0002_0000, -32'sh0002_0000, -32'sh0002_0000, 1'b0});
    pending_points.push_back('{32'sh0, 32'sh0, -32'sh0001_0000, 1'b1});
    pending_points.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1});
    pending_points.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0});
    pending_points.push_back('{32'sh0000_1000, -32'sh0000_1000, -32'sh0000_1000, 1'b0});
    pending_points.push_back('{32'sh0, 32'sh0, -32'sh0000_1001, 1'b1});
    drain();
    write_reg(REG_FB_SIZE, 64'h0000_0000_0000_0780);
    pending_points.push_back('{32'sh0, 32'sh0, -32'sh0001_0000, 1'b0});
    drain();

    // extremes: huge viewport and offsets to hit saturation
    write_reg(REG_FB_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_VP_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_VP_POS, 64'h0000_0000_7FFF_8000);
    write_reg(REG_NEAR, 64'h0000_0000_0000_0000);
    load_camera(500, 1500, 0);
    random_points(200);
    drain();

    write_reg(REG_VP_POS, 64'h0000_0000_8000_7FFF);
    write_reg(REG_VP_SIZE, 64'h0000_0000_0001_0001);
    write_reg(REG_NEAR, 64'h0000_0000_7FFF_FFFF);
    random_points(60);
    drain();

    // random points with the receiver always ready
    write_reg(REG_NEAR, 64'h0000_0000_0000_8000);
    write_reg(REG_VP_SIZE, 64'h0000_0000_02D0_0500);
    write_reg(REG_VP_POS, 64'h0000_0000_0010_FFF0);
    load_camera(800, 1200, 100);
    quiet_out = 1;
    random_points(150);
    drain();
    quiet_out = 0;

    // raw random matrices and registers
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 4; r++) write_reg(r[2:0], {$urandom, $urandom});
      write_reg(REG_NEAR, {32'h0, $urandom});
      write_reg(REG_FB_SIZE, {$urandom, $urandom});
      write_reg(REG_VP_SIZE, {$urandom, $urandom});
      write_reg(REG_VP_POS, {$urandom, $urandom});
      random_points(25);
      drain();
    end
    write_reg(REG_ROW0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ROW1, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_ROW2, 64'h8000_8000_8000_8000);
    write_reg(REG_ROW3, 64'h8000_0000_0000_0000);
    write_reg(REG_NEAR, 64'h0);
    random_points(100);
    drain();
    load_camera(1000, 1000, 0);
    random_points(200);
    drain();

    if (error_count == 0) begin
      $display("** world_to_screen_projection: PASSED **");
    end else begin
      $display("** world_to_screen_projection: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/wsp_pkg.sv
hdl/wsp_front.sv
hdl/wsp_queue.sv
hdl/wsp_back.sv
hdl/world_to_screen_projection.sv
dv/tb_world_to_screen_projection.sv
